@@ design/pldz_pkg.sv @@
package pldz_pkg;

    // history memory geometry
    localparam int HIST_DEPTH = 2048;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int PROD_W     = HIST_AW + 1;

    // token field widths
    localparam int DIST_W   = 11;
    localparam int CNT_W    = 4;
    localparam int STATUS_W = 3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DATA      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_DIST = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FAR_DIST  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

    // byte constants of the format
    localparam logic [7:0]       SPACE_BYTE    = 8'h20;
    localparam logic [7:0]       HIGH_FLIP     = 8'h80;
    localparam logic [CNT_W-1:0] COPY_LEN_BIAS = 4'd3;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       record_end;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [7:0]          out_byte;
        logic [STATUS_W-1:0] status;
        logic                last_of_item;
        logic                end_of_record;
    } out_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic emit_direct;
        logic read_issue;
        logic emit_copy;
        logic emit_err;
        logic finish;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
        logic cnt_nz;
        logic cnt_one;
        logic is_copy;
        logic err_nz;
    } dp_status_t;

endpackage

@@ design/palmdoc_lz77_decompressor_top.sv @@
// PalmDoc LZ77 decompressor.
// Input channel s_*: one compressed byte per item, record_end set on the
// last byte of a record. Result channel m_*: one decompressed byte or one
// error status per item; last_of_item marks the last result of an input
// item, end_of_record the last result of a record (always set on errors).
// An input item may give no result (run headers, first byte of a copy
// pair, bytes after an error), one, two (space pair) or up to ten (copy).
// Order of work: an item is taken while the sequencer is idle, then its
// results are loaded into the output register one at a time. A copied
// byte takes a history read, then its write and output; an error result
// comes after the item's data bytes. The copy rate is set by the
// registered history read that must follow the previous write, since
// copies may overlap.
// s_ready stays low while an item's results are being produced; a stalled
// m_ready holds the output register and freezes the sequencer.
// Reset (synchronous, aresetn low) clears pointers, record and token state;
// the history memory needs no clearing, reads never reach unwritten bytes.
module palmdoc_lz77_decompressor_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pldz_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pldz_pkg::out_item_t m_item
);
    import pldz_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t stat;

    // sequencer
    pldz_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // decode, history and output register
    pldz_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_item  (s_item),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

@@ design/pldz_ram.sv @@
module pldz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/pldz_ctrl.sv @@
module pldz_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pldz_pkg::dp_status_t stat,
    output pldz_pkg::dp_cmd_t    cmd
);
    import pldz_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_COPY = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // sequencer: take an item, then emit its results one at a time
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN: begin
                if (stat.cnt_nz) begin
                    if (stat.is_copy) begin
                        cmd.read_issue = 1'b1;
                        state_next     = S_COPY;
                    end else if (stat.out_free) begin
                        cmd.emit_direct = 1'b1;
                        if (stat.cnt_one && !stat.err_nz) begin
                            cmd.finish = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                end else if (stat.err_nz) begin
                    if (stat.out_free) begin
                        cmd.emit_err = 1'b1;
                        cmd.finish   = 1'b1;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_COPY: begin
                if (stat.out_free) begin
                    cmd.emit_copy = 1'b1;
                    if (stat.cnt_one && !stat.err_nz) begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_RUN;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_one_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_direct, cmd.emit_copy, cmd.emit_err}))
        else $error("more than one result emitted in a cycle");
    a_finish_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> s_ready)
        else $error("not ready after item finished");
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> !s_ready)
        else $error("ready right after an item was taken");
`endif

endmodule

@@ design/pldz_datapath.sv @@
module pldz_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  pldz_pkg::in_item_t   s_item,
    input  pldz_pkg::dp_cmd_t    cmd,
    output pldz_pkg::dp_status_t stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pldz_pkg::out_item_t  m_item
);
    import pldz_pkg::*;

    // decoder token and record state
    logic [HIST_AW-1:0]  wp_reg;
    logic [PROD_W-1:0]   produced_reg;
    logic [CNT_W-1:0]    lit_rem_reg;
    logic                pair_pend_reg;
    logic [5:0]          pair_high_reg;
    logic                err_latched_reg;

    // plan of the item at work
    logic                end_reg;
    logic [STATUS_W-1:0] err_reg;
    logic                copy_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [7:0]          byte0_reg;
    logic [7:0]          byte1_reg;
    logic [DIST_W-1:0]   dist_reg;

    // output register
    logic                m_valid_reg;
    out_item_t           m_item_reg;

    // decode results
    logic [7:0]          b;
    logic [DIST_W-1:0]   pair_dist;
    logic [CNT_W-1:0]    pair_len;
    logic [CNT_W-1:0]    dec_cnt;
    logic                dec_copy;
    logic [STATUS_W-1:0] dec_err;
    logic [7:0]          dec_b0;
    logic [7:0]          dec_b1;
    logic [CNT_W-1:0]    lit_rem_next;
    logic                pair_pend_next;
    logic [5:0]          pair_high_next;

    logic                data_emit;
    logic                last_data;
    logic [7:0]          emit_byte;
    logic [7:0]          ram_rdata;
    logic [HIST_AW-1:0]  rd_addr;

    assign b         = s_item.data_byte;
    assign pair_dist = {pair_high_reg, b[7:3]};
    assign pair_len  = CNT_W'(b[2:0]) + COPY_LEN_BIAS;

    // token decode of the incoming byte
    always_comb begin
        dec_cnt        = '0;
        dec_copy       = 1'b0;
        dec_err        = ST_DATA;
        dec_b0         = b;
        dec_b1         = b ^ HIGH_FLIP;
        lit_rem_next   = lit_rem_reg;
        pair_pend_next = pair_pend_reg;
        pair_high_next = pair_high_reg;
        if (err_latched_reg) begin
            dec_cnt = '0;
        end else if (lit_rem_reg != '0) begin
            dec_cnt      = CNT_W'(1);
            lit_rem_next = lit_rem_reg - CNT_W'(1);
        end else if (pair_pend_reg) begin
            pair_pend_next = 1'b0;
            pair_high_next = '0;
            if (PROD_W'(pair_dist) > produced_reg) begin
                dec_err = ST_FAR_DIST;
            end else if (pair_dist == '0) begin
                dec_err = ST_ZERO_DIST;
            end else begin
                dec_cnt  = pair_len;
                dec_copy = 1'b1;
            end
        end else if (b inside {8'h00, [8'h09:8'h7f]}) begin
            dec_cnt = CNT_W'(1);
        end else if (b inside {[8'h01:8'h08]}) begin
            lit_rem_next = b[CNT_W-1:0];
        end else if (b inside {[8'h80:8'hbf]}) begin
            pair_pend_next = 1'b1;
            pair_high_next = b[5:0];
        end else begin
            dec_cnt = CNT_W'(2);
            dec_b0  = SPACE_BYTE;
        end
        // end of record checks
        if (!err_latched_reg && dec_err == ST_DATA && s_item.record_end) begin
            if (lit_rem_next != '0 || pair_pend_next) begin
                dec_err = ST_TRUNC;
            end else if (produced_reg == '0 && dec_cnt == '0) begin
                dec_err = ST_EMPTY;
            end
        end
    end

    // token state, record state and item plan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lit_rem_reg     <= '0;
            pair_pend_reg   <= 1'b0;
            pair_high_reg   <= '0;
            err_latched_reg <= 1'b0;
            end_reg         <= 1'b0;
            err_reg         <= ST_DATA;
            copy_reg        <= 1'b0;
            cnt_reg         <= '0;
        end else begin
            if (cmd.accept) begin
                lit_rem_reg   <= lit_rem_next;
                pair_pend_reg <= pair_pend_next;
                pair_high_reg <= pair_high_next;
                end_reg       <= s_item.record_end;
                err_reg       <= dec_err;
                copy_reg      <= dec_copy;
                cnt_reg       <= dec_cnt;
            end else if (data_emit) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            if (cmd.finish) begin
                if (end_reg) begin
                    lit_rem_reg     <= '0;
                    pair_pend_reg   <= 1'b0;
                    pair_high_reg   <= '0;
                    err_latched_reg <= 1'b0;
                end else if (err_reg != ST_DATA) begin
                    lit_rem_reg     <= '0;
                    pair_pend_reg   <= 1'b0;
                    pair_high_reg   <= '0;
                    err_latched_reg <= 1'b1;
                end
            end
        end
    end

    // history pointer and record byte count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            produced_reg <= '0;
        end else begin
            if (data_emit) begin
                wp_reg <= wp_reg + HIST_AW'(1);
            end
            if (cmd.finish && end_reg) begin
                produced_reg <= '0;
            end else if (data_emit && produced_reg < PROD_W'(HIST_DEPTH)) begin
                produced_reg <= produced_reg + PROD_W'(1);
            end
        end
    end

    // direct bytes of the item, shifted out in order
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte0_reg <= dec_b0;
            byte1_reg <= dec_b1;
            dist_reg  <= pair_dist;
        end else if (cmd.emit_direct) begin
            byte0_reg <= byte1_reg;
        end
    end

    assign data_emit = cmd.emit_direct | cmd.emit_copy;
    assign emit_byte = cmd.emit_copy ? ram_rdata : byte0_reg;
    assign last_data = (cnt_reg == CNT_W'(1)) && (err_reg == ST_DATA);
    assign rd_addr   = wp_reg - HIST_AW'(dist_reg);

    // history memory
    pldz_ram #(
        .WIDTH(8),
        .DEPTH(HIST_DEPTH)
    ) u_hist (
        .aclk  (aclk),
        .we    (data_emit),
        .waddr (wp_reg),
        .wdata (emit_byte),
        .re    (cmd.read_issue),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (data_emit || cmd.emit_err) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (data_emit) begin
            m_item_reg.out_byte      <= emit_byte;
            m_item_reg.status        <= ST_DATA;
            m_item_reg.last_of_item  <= last_data;
            m_item_reg.end_of_record <= last_data && end_reg;
        end else if (cmd.emit_err) begin
            m_item_reg.out_byte      <= '0;
            m_item_reg.status        <= err_reg;
            m_item_reg.last_of_item  <= 1'b1;
            m_item_reg.end_of_record <= 1'b1;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // status to the controller
    assign stat.out_free = !m_valid_reg || m_ready;
    assign stat.cnt_nz   = (cnt_reg != '0);
    assign stat.cnt_one  = (cnt_reg == CNT_W'(1));
    assign stat.is_copy  = copy_reg;
    assign stat.err_nz   = (err_reg != ST_DATA);

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (data_emit || cmd.emit_err) |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending item");
    a_cnt_live: assert property (@(posedge aclk) disable iff (!aresetn)
        data_emit |-> (cnt_reg != '0))
        else $error("data byte emitted with no bytes left");
    a_prod_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        produced_reg <= PROD_W'(HIST_DEPTH))
        else $error("record byte count above history depth");
`endif

endmodule
